// ===== src/tpmw_pkg.sv =====
// tpmw_pkg: shared types and constants for the trie prefix max-weight block.
// No dependencies; compile before every other file in src.
package tpmw_pkg;

    localparam int LETTER_W = 5;
    localparam int WEIGHT_W = 32;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FOUND = 2'd1,
        STATUS_MISS  = 2'd2,
        STATUS_FULL  = 2'd3
    } status_t;

endpackage

// ===== src/tpmw_ram.sv =====
// tpmw_ram: simple dual-port synchronous RAM, one write and one read port,
// registered read data. No dependencies.
module tpmw_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/trie_prefix_max_weight.sv =====
// trie_prefix_max_weight: top level, sequencer around the child-table and
// best-weight memories. Depends on tpmw_pkg and tpmw_ram.
//
// Usage: each input word carries one letter of a string (s_mode 0 insert,
// 1 query), s_last on the final letter, and the insert weight on s_weight.
// Only a word with s_last high produces a result word on the m_ channel:
// m_status (done / found / not found / table full) and m_best.
// Sequence: a letter that walks the trie takes a child-table read, then
// the update (ST_LOOK), the registered read data feeding the next letter's
// address. A last letter that reaches a node adds a best-weight
// read-modify-write (ST_BRD, ST_BUSE) and the output load (ST_FIN); a last
// letter whose lookup breaks the path goes from ST_LOOK to ST_FIN. A letter
// on an already broken path or out of range takes no lookup; if it is the
// last one it goes straight to ST_FIN. One word is in flight at a time.
// Reset: synchronous, active low. After reset a clearing pass writes zero
// to every entry of both memories, during which s_ready stays low.
// Stall: the result register holds while m_ready is low; the next word is
// accepted meanwhile, and a later result waits until the register frees.
module trie_prefix_max_weight #(
    parameter int NODES    = 4096,
    parameter int ALPHABET = 26
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_mode,
    input  logic [tpmw_pkg::LETTER_W-1:0] s_letter,
    input  logic                          s_last,
    input  logic [tpmw_pkg::WEIGHT_W-1:0] s_weight,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_status,
    output logic [tpmw_pkg::WEIGHT_W-1:0] m_best
);

    localparam int NODE_W = $clog2(NODES);
    localparam int SLOTS  = NODES * ALPHABET;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int W_W    = tpmw_pkg::WEIGHT_W;
    localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODES - 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_BRD,
        ST_BUSE,
        ST_FIN
    } state_t;

    state_t              state_reg,   state_next;
    logic                clr_busy_reg, clr_busy_next;
    logic [SLOT_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [NODE_W-1:0]   cur_reg,     cur_next;
    logic [NODE_W-1:0]   nf_reg,      nf_next;
    logic                broken_reg,  broken_next;
    logic                mode_reg,    mode_next;
    logic                last_reg,    last_next;
    logic [W_W-1:0]      weight_reg,  weight_next;
    logic [SLOT_W-1:0]   slot_reg,    slot_next;
    logic [W_W-1:0]      hold_reg,    hold_next;
    logic                m_valid_reg, m_valid_next;
    tpmw_pkg::status_t   m_status_reg, m_status_next;
    logic [W_W-1:0]      m_best_reg,  m_best_next;

    logic                child_we, child_re;
    logic [SLOT_W-1:0]   child_waddr, child_raddr;
    logic [NODE_W-1:0]   child_wdata, child_rdata;
    logic                best_we, best_re;
    logic [NODE_W-1:0]   best_waddr, best_raddr;
    logic [W_W-1:0]      best_wdata, best_rdata;

    logic                letter_ok;
    logic [SLOT_W-1:0]   slot_addr;
    logic [NODE_W-1:0]   nf_inc;

    tpmw_ram #(.DEPTH(SLOTS), .WIDTH(NODE_W)) u_child (
        .clk     (aclk),
        .wr_en   (child_we),
        .wr_addr (child_waddr),
        .wr_data (child_wdata),
        .rd_en   (child_re),
        .rd_addr (child_raddr),
        .rd_data (child_rdata)
    );

    tpmw_ram #(.DEPTH(NODES), .WIDTH(W_W)) u_best (
        .clk     (aclk),
        .wr_en   (best_we),
        .wr_addr (best_waddr),
        .wr_data (best_wdata),
        .rd_en   (best_re),
        .rd_addr (best_raddr),
        .rd_data (best_rdata)
    );

    assign letter_ok = 32'(s_letter) < 32'(ALPHABET);
    assign slot_addr = SLOT_W'(cur_reg) * SLOT_W'(ALPHABET) + SLOT_W'(s_letter);
    assign nf_inc    = nf_reg + NODE_W'(1);
    assign s_ready   = (state_reg == ST_IDLE) && !clr_busy_reg;
    assign m_valid   = m_valid_reg;
    assign m_status  = m_status_reg;
    assign m_best    = m_best_reg;

    always_comb begin
        state_next    = state_reg;
        clr_busy_next = clr_busy_reg;
        clr_cnt_next  = clr_cnt_reg;
        cur_next      = cur_reg;
        nf_next       = nf_reg;
        broken_next   = broken_reg;
        mode_next     = mode_reg;
        last_next     = last_reg;
        weight_next   = weight_reg;
        slot_next     = slot_reg;
        hold_next     = hold_reg;
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_best_next   = m_best_reg;
        child_we      = 1'b0;
        child_waddr   = slot_reg;
        child_wdata   = '0;
        child_re      = 1'b0;
        child_raddr   = slot_addr;
        best_we       = 1'b0;
        best_waddr    = cur_reg;
        best_wdata    = weight_reg;
        best_re       = 1'b0;
        best_raddr    = cur_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // clear both memories after reset
        if (clr_busy_reg) begin
            child_we     = 1'b1;
            child_waddr  = clr_cnt_reg;
            best_we      = 1'b1;
            best_waddr   = clr_cnt_reg[NODE_W-1:0];
            best_wdata   = '0;
            clr_cnt_next = clr_cnt_reg + SLOT_W'(1);
            if (clr_cnt_reg == LAST_SLOT) begin
                clr_busy_next = 1'b0;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    mode_next   = s_mode;
                    last_next   = s_last;
                    weight_next = s_weight;
                    slot_next   = slot_addr;
                    if (broken_reg || !letter_ok) begin
                        broken_next = 1'b1;
                        if (s_last) begin
                            state_next = ST_FIN;
                        end
                    end else begin
                        child_re   = 1'b1;
                        best_re    = 1'b1;
                        state_next = ST_LOOK;
                    end
                end
            end
            ST_LOOK: begin
                if (mode_reg) begin
                    if (child_rdata == '0) begin
                        broken_next = 1'b1;
                        state_next  = last_reg ? ST_FIN : ST_IDLE;
                    end else begin
                        cur_next   = child_rdata;
                        state_next = last_reg ? ST_BRD : ST_IDLE;
                    end
                end else begin
                    if (best_rdata < weight_reg) begin
                        best_we = 1'b1;
                    end
                    if (child_rdata != '0) begin
                        cur_next   = child_rdata;
                        state_next = last_reg ? ST_BRD : ST_IDLE;
                    end else if (nf_reg == LAST_NODE) begin
                        broken_next = 1'b1;
                        state_next  = last_reg ? ST_FIN : ST_IDLE;
                    end else begin
                        nf_next     = nf_inc;
                        child_we    = 1'b1;
                        child_wdata = nf_inc;
                        cur_next    = nf_inc;
                        state_next  = last_reg ? ST_BRD : ST_IDLE;
                    end
                end
            end
            ST_BRD: begin
                best_re    = 1'b1;
                state_next = ST_BUSE;
            end
            ST_BUSE: begin
                hold_next = best_rdata;
                if (!mode_reg && (best_rdata < weight_reg)) begin
                    best_we = 1'b1;
                end
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    if (mode_reg) begin
                        m_status_next = broken_reg ? tpmw_pkg::STATUS_MISS
                                                   : tpmw_pkg::STATUS_FOUND;
                        m_best_next   = broken_reg ? '0 : hold_reg;
                    end else begin
                        m_status_next = broken_reg ? tpmw_pkg::STATUS_FULL
                                                   : tpmw_pkg::STATUS_DONE;
                        m_best_next   = '0;
                    end
                    cur_next    = '0;
                    broken_next = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            cur_reg      <= '0;
            nf_reg       <= '0;
            broken_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_busy_reg <= clr_busy_next;
            clr_cnt_reg  <= clr_cnt_next;
            cur_reg      <= cur_next;
            nf_reg       <= nf_next;
            broken_reg   <= broken_next;
            m_valid_reg  <= m_valid_next;
        end
        mode_reg     <= mode_next;
        last_reg     <= last_next;
        weight_reg   <= weight_next;
        slot_reg     <= slot_next;
        hold_reg     <= hold_next;
        m_status_reg <= m_status_next;
        m_best_reg   <= m_best_next;
    end

    a_alloc_on_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && (nf_reg != $past(nf_reg))) |->
            ($past(state_reg) == ST_LOOK && !$past(mode_reg) && nf_reg == $past(nf_inc)))
        else $error("node allocated outside an insert lookup");

    a_result_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && $rose(m_valid_reg)) |-> ($past(state_reg) == ST_FIN))
        else $error("result raised outside the finish state");

    a_read_path_intact: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BRD || state_reg == ST_BUSE) |-> !broken_reg)
        else $error("final node read on a broken path");

    a_child_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (child_we && !clr_busy_reg) |-> (child_wdata != '0))
        else $error("child table written with the no-child code");

    a_no_work_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy_reg |-> (state_reg == ST_IDLE && !m_valid_reg))
        else $error("item in flight during the clearing pass");

endmodule

// ===== tb/tpmw_tb_pkg.sv =====
// tpmw_tb_pkg: trie shadow scoreboard for the trie prefix max-weight testbench.
// Tracks nodes, best weights and the current walk, and queues the expected result words.
// Depends on tpmw_pkg.
package tpmw_tb_pkg;

    localparam int NODES    = 4096;
    localparam int ALPHABET = 26;
    localparam int NODE_W   = 12;

    typedef struct {
        tpmw_pkg::status_t           status;
        bit [tpmw_pkg::WEIGHT_W-1:0] best;
    } trie_result_t;

    class trie_mirror;
        bit [NODE_W-1:0]             child_of [NODES*ALPHABET];
        bit [tpmw_pkg::WEIGHT_W-1:0] node_best [NODES];
        bit [NODE_W:0]               last_alloc;
        bit [NODE_W-1:0]             walk_node;
        bit                          walk_broken;
        trie_result_t                awaited [$];
        int                          mismatches;

        function int nodes_left();
            return NODES - 1 - int'(last_alloc);
        endfunction

        function int awaiting();
            return awaited.size();
        endfunction

        function void raise_best(bit [NODE_W-1:0] node, bit [tpmw_pkg::WEIGHT_W-1:0] w);
            if (node_best[node] < w) begin
                node_best[node] = w;
            end
        endfunction

        function void apply_letter(bit mode, bit [tpmw_pkg::LETTER_W-1:0] letter, bit last,
                                   bit [tpmw_pkg::WEIGHT_W-1:0] w);
            int              slot;
            bit [NODE_W-1:0] child;
            trie_result_t    r;
            if (!walk_broken) begin
                if (letter >= ALPHABET) begin
                    walk_broken = 1'b1;
                end else begin
                    slot  = int'(walk_node) * ALPHABET + int'(letter);
                    child = child_of[slot];
                    if (mode) begin
                        if (child == 0) begin
                            walk_broken = 1'b1;
                        end else begin
                            walk_node = child;
                        end
                    end else begin
                        raise_best(walk_node, w);
                        if (child == 0) begin
                            if (int'(last_alloc) + 1 >= NODES) begin
                                walk_broken = 1'b1;
                            end else begin
                                last_alloc     = last_alloc + 1'b1;
                                child          = last_alloc[NODE_W-1:0];
                                child_of[slot] = child;
                            end
                        end
                        if (!walk_broken) begin
                            walk_node = child;
                            if (last) begin
                                raise_best(walk_node, w);
                            end
                        end
                    end
                end
            end
            if (!last) begin
                return;
            end
            r.best = '0;
            if (mode && !walk_broken) begin
                r.status = tpmw_pkg::STATUS_FOUND;
                r.best   = node_best[walk_node];
            end else if (mode) begin
                r.status = tpmw_pkg::STATUS_MISS;
            end else if (walk_broken) begin
                r.status = tpmw_pkg::STATUS_FULL;
            end else begin
                r.status = tpmw_pkg::STATUS_DONE;
            end
            awaited.push_back(r);
            walk_node   = '0;
            walk_broken = 1'b0;
        endfunction

        function void check_result(logic [1:0] status, logic [tpmw_pkg::WEIGHT_W-1:0] best);
            trie_result_t want;
            if (awaited.size() == 0) begin
                $error("result word with nothing expected: status %0d best %0h",
                       status, best);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            if (status !== want.status) begin
                $error("status mismatch: expected %0d, actual %0d", want.status, status);
                mismatches++;
            end
            if (best !== want.best) begin
                $error("best mismatch: expected %0h, actual %0h", want.best, best);
                mismatches++;
            end
        endfunction
    endclass

endpackage

// ===== tb/tb_trie_prefix_max_weight.sv =====
// tb_trie_prefix_max_weight: testbench top; drives letter words through the trie
// block under varying idle and stall patterns, including a full node pool.
// Depends on tpmw_pkg, tpmw_tb_pkg and trie_prefix_max_weight.
module tb_trie_prefix_max_weight;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 20;
    localparam int KEY_MAX     = 24;

    typedef bit [tpmw_pkg::LETTER_W-1:0] letter_t;
    typedef bit [tpmw_pkg::WEIGHT_W-1:0] weight_t;

    typedef struct {
        int      len;
        letter_t lt [KEY_MAX];
    } trie_key_t;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_valid  = 1'b0;
    logic                          s_ready;
    logic                          s_mode   = 1'b0;
    logic [tpmw_pkg::LETTER_W-1:0] s_letter = '0;
    logic                          s_last   = 1'b0;
    logic [tpmw_pkg::WEIGHT_W-1:0] s_weight = '0;
    logic                          m_valid;
    logic                          m_ready  = 1'b0;
    logic [1:0]                    m_status;
    logic [tpmw_pkg::WEIGHT_W-1:0] m_best;

    tpmw_tb_pkg::trie_mirror mirror = new;
    trie_key_t  inserted_keys [$];
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         hold_requests  = 0;
    int         hold_served    = 0;
    int         hold_left      = 0;
    int         letters_sent   = 0;

    trie_prefix_max_weight #(
        .NODES    (tpmw_tb_pkg::NODES),
        .ALPHABET (tpmw_tb_pkg::ALPHABET)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_mode   (s_mode),
        .s_letter (s_letter),
        .s_last   (s_last),
        .s_weight (s_weight),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_status (m_status),
        .m_best   (m_best)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10ms;
        $display("tb_trie_prefix_max_weight: FAIL");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                mirror.check_result(m_status, m_best);
            end
        end
    end

    function automatic weight_t rand_weight();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_letter(input bit mode, input letter_t letter,
                               input bit last, input weight_t w);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_mode   <= mode;
        s_letter <= letter;
        s_last   <= last;
        s_weight <= w;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        mirror.apply_letter(mode, letter, last, w);
        letters_sent++;
    endtask

    task automatic send_key(input trie_key_t k, input bit mode, input weight_t w);
        for (int i = 0; i < k.len; i++) begin
            send_letter(mode, k.lt[i], i == k.len - 1, w);
        end
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (mirror.awaiting() > 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic send_random_string();
        trie_key_t k;
        int        kind;
        int        top;
        weight_t   w;
        kind  = $urandom_range(99);
        top   = ($urandom_range(3) == 0) ? tpmw_tb_pkg::ALPHABET - 1 : 3;
        k.len = $urandom_range(1, 6);
        foreach (k.lt[i]) begin
            k.lt[i] = letter_t'($urandom_range(top));
        end
        w = rand_weight();
        if (kind < 45) begin
            send_key(k, 1'b0, w);
            inserted_keys.push_back(k);
        end else if (kind < 85) begin
            // mostly prefixes of stored keys so queries hit
            if (inserted_keys.size() > 0 && $urandom_range(9) < 7) begin
                k     = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
                k.len = $urandom_range(1, k.len);
            end
            send_key(k, 1'b1, w);
        end else begin
            for (int i = 0; i < k.len; i++) begin
                send_letter(bit'($urandom_range(1)),
                            (kind < 93) ? k.lt[i] : letter_t'($urandom_range(31)),
                            i == k.len - 1, w);
            end
        end
    endtask

    task automatic run_phase(input int n, input int idle, input int stall, input bit hold);
        int target;
        target         = letters_sent + n;
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        if (hold) begin
            hold_requests++;
        end
        while (letters_sent < target) begin
            send_random_string();
        end
        wait_drained();
    endtask

    task automatic fill_pool();
        trie_key_t k;
        send_idle_pct  = 5;
        recv_stall_pct = 5;
        while (mirror.nodes_left() > 0) begin
            k.len = KEY_MAX;
            foreach (k.lt[i]) begin
                k.lt[i] = letter_t'($urandom_range(tpmw_tb_pkg::ALPHABET - 1));
            end
            send_key(k, 1'b0, $urandom);
            inserted_keys.push_back(k);
        end
        // pool exhausted: new paths stop, existing ones still work
        repeat (4) begin
            foreach (k.lt[i]) begin
                k.lt[i] = letter_t'($urandom_range(tpmw_tb_pkg::ALPHABET - 1));
            end
            send_key(k, 1'b0, rand_weight());
        end
        repeat (6) begin
            k     = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
            k.len = $urandom_range(1, k.len);
            send_key(k, 1'b1, $urandom);
        end
        k = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
        send_key(k, 1'b0, '1);
        send_key(k, 1'b1, '0);
        wait_drained();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_letter(1'b1, 5'd0, 1'b1, '0);
        send_letter(1'b0, 5'd25, 1'b1, '1);
        send_letter(1'b0, 5'd0, 1'b0, '0);
        send_letter(1'b0, 5'd1, 1'b1, '0);
        send_letter(1'b1, 5'd25, 1'b1, '1);
        send_letter(1'b1, 5'd0, 1'b1, '0);
        send_letter(1'b0, 5'd0, 1'b0, 32'd5);
        send_letter(1'b0, 5'd1, 1'b0, 32'd5);
        send_letter(1'b0, 5'd2, 1'b1, 32'd5);
        send_letter(1'b1, 5'd0, 1'b0, '0);
        send_letter(1'b1, 5'd1, 1'b1, '0);
        // out-of-range letter breaks an insert
        send_letter(1'b0, 5'd0, 1'b0, 32'd7);
        send_letter(1'b0, 5'd31, 1'b0, 32'd7);
        send_letter(1'b0, 5'd1, 1'b1, 32'd7);
        send_letter(1'b1, 5'd26, 1'b1, '0);
        send_letter(1'b1, 5'd3, 1'b0, '0);
        send_letter(1'b1, 5'd0, 1'b1, '0);
        // mode changes within a string
        send_letter(1'b0, 5'd0, 1'b0, 32'd9);
        send_letter(1'b1, 5'd1, 1'b1, '0);
        send_letter(1'b1, 5'd16, 1'b0, '0);
        send_letter(1'b0, 5'd2, 1'b1, 32'd9);
        wait_drained();

        run_phase(125, 0, 0, 1'b1);
        run_phase(125, 48, 0, 1'b0);
        run_phase(125, 0, 48, 1'b0);
        run_phase(125, 23, 23, 1'b0);
        fill_pool();
        run_phase(60, 23, 23, 1'b1);

        if (mirror.mismatches == 0 && mirror.awaiting() == 0) begin
            $display("tb_trie_prefix_max_weight: PASS");
        end else begin
            $display("tb_trie_prefix_max_weight: FAIL");
        end
        $finish;
    end

endmodule
